// ----- rtl/minutiae_window_classifier_defines.svh -----
// assertion macros shared by the checker of the minutiae window classifier
`ifndef MINUTIAE_WINDOW_CLASSIFIER_DEFINES_SVH
`define MINUTIAE_WINDOW_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// check that also runs while rst is high
`define MWC_ASSERT_ALWAYS(label, cons, msg) \
  label: assert property (@(posedge clk) (cons)) else $error(msg);

`endif

// ----- rtl/mwc_pkg.sv -----
// types, constants and the fork pattern test of the minutiae window classifier
`timescale 1ns / 1ps

package mwc_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 11;
  localparam int ORIENT_BITS  = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int WIN_BITS     = 9;
  localparam int NUM_FORKS    = 16;
  localparam int CENTER_BIT   = 4;
  localparam int MIN_DIM      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // window bit positions: column-major, top row first
  localparam logic [WIN_BITS-1:0] NW = 9'b000000001;
  localparam logic [WIN_BITS-1:0] WW = 9'b000000010;
  localparam logic [WIN_BITS-1:0] SW = 9'b000000100;
  localparam logic [WIN_BITS-1:0] NN = 9'b000001000;
  localparam logic [WIN_BITS-1:0] SS = 9'b000100000;
  localparam logic [WIN_BITS-1:0] NE = 9'b001000000;
  localparam logic [WIN_BITS-1:0] EE = 9'b010000000;
  localparam logic [WIN_BITS-1:0] SE = 9'b100000000;

  localparam logic [WIN_BITS-1:0] FORK_PATTERNS [NUM_FORKS] = '{
    WW | NE | SE, NN | SW | SE, NW | SW | EE, NW | NE | SS,
    NW | SS | EE, WW | NN | SE, NN | SW | EE, WW | SS | NE,
    NW | SW | SE, NW | NE | SW, NE | SW | SE, NW | NE | SE,
    WW | EE | SS, WW | EE | NN, NN | SS | WW, NN | SS | EE
  };

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

  typedef struct packed {
    logic [ORIENT_BITS-1:0] orient;
    logic                   newer;
    logic                   older;
  } line_word_t;

  function automatic logic is_fork(input logic [WIN_BITS-1:0] win);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_FORKS; i++) begin
      if ((win & FORK_PATTERNS[i]) == FORK_PATTERNS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(MIN_DIM)) r = DIM_W'(MIN_DIM);
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- rtl/mwc_if.sv -----
// valid/ready channel interfaces for pixels, minutiae and configuration
`timescale 1ns / 1ps

interface mwc_pixel_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      ridge_bit;
  logic signed [mwc_pkg::ORIENT_BITS-1:0]    orientation_in;
  modport source (output valid, ridge_bit, orientation_in, input ready);
  modport sink (input valid, ridge_bit, orientation_in, output ready);
endinterface

interface mwc_minutia_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      minutia_type;
  logic        [mwc_pkg::ROW_W-1:0]          point_row;
  logic        [mwc_pkg::COL_W-1:0]          point_column;
  logic signed [mwc_pkg::ORIENT_BITS-1:0]    point_orientation;
  modport source (output valid, minutia_type, point_row, point_column, point_orientation,
                  input ready);
  modport sink (input valid, minutia_type, point_row, point_column, point_orientation,
                output ready);
endinterface

interface mwc_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic        [mwc_pkg::CFG_IDX_W-1:0]      index;
  logic        [mwc_pkg::DIM_W-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/minutiae_window_classifier.sv -----
// top level: line buffers, 3x3 window and minutia classification
// stage 1 holds an accepted pixel word, the output word register its minutia word
// throughput: one pixel per cycle unless stalled; line buffer read at accept,
// written at stage 1 advance; a stalled minutia output holds the pipe and pixel ready
// reset: synchronous; then a clear of all 1024 line buffer words with pixel ready low
// configuration writes are taken in every cycle outside reset, also during the clear
`timescale 1ns / 1ps

module minutiae_window_classifier (
  input  logic           clk,
  input  logic           rst,
  mwc_pixel_if.sink      pixel,
  mwc_minutia_if.source  minutia,
  mwc_cfg_if.sink        cfg
);

  logic [mwc_pkg::DIM_W-1:0]       image_width, image_height;
  logic [mwc_pkg::COL_W:0]         clear_cnt;
  logic                            clearing;
  logic                            pix_acc;
  mwc_pkg::pos_t                   cur;

  mwc_pkg::line_word_t             line_mem [mwc_pkg::MAX_WIDTH];
  mwc_pkg::line_word_t             rd_word, wr_word;
  logic                            mem_we;
  logic [mwc_pkg::COL_W-1:0]       mem_waddr;

  logic                            s1_valid, s1_bit;
  logic [mwc_pkg::ORIENT_BITS-1:0] s1_orient;
  logic [mwc_pkg::COL_W-1:0]       s1_col;
  logic [mwc_pkg::ROW_W-1:0]       s1_row;
  logic                            s1_adv, out_free, emit;

  logic [mwc_pkg::WIN_BITS-1:0]    window_bits, window_next;
  logic [mwc_pkg::ORIENT_BITS-1:0] odelay0, odelay1;

  logic                            out_valid, out_type;
  logic [mwc_pkg::ROW_W-1:0]       out_row;
  logic [mwc_pkg::COL_W-1:0]       out_col;
  logic [mwc_pkg::ORIENT_BITS-1:0] out_orient;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mwc_pkg::DIM_W'(mwc_pkg::MAX_WIDTH);
      image_height <= mwc_pkg::DIM_W'(mwc_pkg::HEIGHT_LIMIT);
    end else if (cfg.valid) begin
      if (cfg.index == mwc_pkg::REG_IMAGE_WIDTH) image_width <= cfg.data;
      if (cfg.index == mwc_pkg::REG_IMAGE_HEIGHT) image_height <= cfg.data;
    end
  end

  // line buffer clear after reset
  assign clearing = !clear_cnt[mwc_pkg::COL_W];

  always_ff @(posedge clk) begin
    if (rst) clear_cnt <= '0;
    else if (clearing) clear_cnt <= clear_cnt + (mwc_pkg::COL_W+1)'(1);
  end

  // handshake
  assign out_free    = !out_valid || minutia.ready;
  assign s1_adv      = s1_valid && out_free;
  assign pixel.ready = !clearing && (!s1_valid || out_free);
  assign pix_acc     = pixel.valid && pixel.ready;

  mwc_raster_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (pix_acc),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (cur)
  );

  // line buffer: older row, newer row, orientation of the row above
  always_comb begin
    wr_word.orient = s1_orient;
    wr_word.newer  = s1_bit;
    wr_word.older  = rd_word.newer;
    mem_we         = clearing || s1_adv;
    mem_waddr      = s1_col;
    if (clearing) begin
      wr_word   = '0;
      mem_waddr = clear_cnt[mwc_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= wr_word;
    if (pix_acc) rd_word <= line_mem[cur.col];
  end

  // stage 1: pixel with its line buffer column
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (pix_acc) s1_valid <= 1'b1;
    else if (s1_adv) s1_valid <= 1'b0;
    if (pix_acc) begin
      s1_bit    <= pixel.ridge_bit;
      s1_orient <= pixel.orientation_in;
      s1_col    <= cur.col;
      s1_row    <= cur.row;
    end
  end

  always_comb begin
    window_next = {s1_bit, rd_word.newer, rd_word.older,
                   window_bits[mwc_pkg::WIN_BITS-1:3]};
    emit = (s1_row >= mwc_pkg::ROW_W'(2)) && (s1_col >= mwc_pkg::COL_W'(2))
           && window_next[mwc_pkg::CENTER_BIT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      odelay0     <= '0;
      odelay1     <= '0;
    end else if (s1_adv) begin
      window_bits <= window_next;
      odelay0     <= rd_word.orient;
      odelay1     <= odelay0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s1_adv && emit) out_valid <= 1'b1;
    else if (minutia.ready) out_valid <= 1'b0;
    if (s1_adv && emit) begin
      out_type   <= mwc_pkg::is_fork(window_next);
      out_row    <= s1_row - mwc_pkg::ROW_W'(1);
      out_col    <= s1_col - mwc_pkg::COL_W'(1);
      out_orient <= odelay0;
    end
  end

  assign minutia.valid             = out_valid;
  assign minutia.minutia_type      = out_type;
  assign minutia.point_row         = out_row;
  assign minutia.point_column      = out_col;
  assign minutia.point_orientation = out_orient;

endmodule

// ----- rtl/mwc_raster_pos.sv -----
// raster position counters with wrap against the clamped image size
`timescale 1ns / 1ps

module mwc_raster_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [mwc_pkg::DIM_W-1:0]   image_width,
  input  logic [mwc_pkg::DIM_W-1:0]   image_height,
  output mwc_pkg::pos_t               pos
);

  logic [mwc_pkg::COL_W-1:0] column_count, column_count_next;
  logic [mwc_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [mwc_pkg::DIM_W-1:0] eff_w, eff_h;
  logic [mwc_pkg::DIM_W-1:0] pre_row, post_col, post_row;
  logic [mwc_pkg::COL_W-1:0] pre_col;

  always_comb begin
    eff_w = mwc_pkg::clamp_dim(image_width, mwc_pkg::DIM_W'(mwc_pkg::MAX_WIDTH));
    eff_h = mwc_pkg::clamp_dim(image_height, mwc_pkg::DIM_W'(mwc_pkg::HEIGHT_LIMIT));

    // wrap before taking the pixel, in case the size shrank
    pre_col = column_count;
    pre_row = mwc_pkg::DIM_W'(row_count);
    if (mwc_pkg::DIM_W'(column_count) >= eff_w) begin
      pre_col = '0;
      pre_row = pre_row + mwc_pkg::DIM_W'(1);
    end
    if (pre_row >= eff_h) pre_row = '0;

    // step and wrap after the pixel
    post_col = mwc_pkg::DIM_W'(pre_col) + mwc_pkg::DIM_W'(1);
    post_row = pre_row;
    if (post_col >= eff_w) begin
      post_col = '0;
      post_row = pre_row + mwc_pkg::DIM_W'(1);
    end
    if (post_row >= eff_h) post_row = '0;

    column_count_next = post_col[mwc_pkg::COL_W-1:0];
    row_count_next    = post_row[mwc_pkg::ROW_W-1:0];
    pos.col           = pre_col;
    pos.row           = pre_row[mwc_pkg::ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ----- rtl/mwc_checker.sv -----
// port-level checks of the minutiae window classifier, bound to the top level
`timescale 1ns / 1ps
`include "minutiae_window_classifier_defines.svh"

module mwc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            pix_ready,
  input logic                            cfg_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_type,
  input logic [mwc_pkg::ROW_W-1:0]       out_row,
  input logic [mwc_pkg::COL_W-1:0]       out_col,
  input logic [mwc_pkg::ORIENT_BITS-1:0] out_orient
);

  `MWC_ASSERT_NOW(a_interior_only, out_valid, (out_row != '0) && (out_col != '0), "minutia word on the image border")
  `MWC_ASSERT_NOW(a_clear_after_reset, $past(rst), !pix_ready, "pixel ready during line buffer clear")
  `MWC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")
  `MWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_type) && $stable(out_row) && $stable(out_col) && $stable(out_orient), "stalled minutia word changed")

endmodule

bind minutiae_window_classifier mwc_checker u_mwc_checker (
  .clk        (clk),
  .rst        (rst),
  .pix_ready  (pixel.ready),
  .cfg_ready  (cfg.ready),
  .out_valid  (minutia.valid),
  .out_ready  (minutia.ready),
  .out_type   (minutia.minutia_type),
  .out_row    (minutia.point_row),
  .out_col    (minutia.point_column),
  .out_orient (minutia.point_orientation)
);

// ----- test/tb_minutiae_window_classifier.sv -----
// testbench for the minutiae window classifier: random binary images against a line buffer model
`timescale 1ns / 1ps

module tb_minutiae_window_classifier;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 380;
  localparam int ROW_W         = mwc_pkg::ROW_W;
  localparam int COL_W         = mwc_pkg::COL_W;
  localparam int OW            = mwc_pkg::ORIENT_BITS;
  localparam int DW            = mwc_pkg::DIM_W;

  // window bits: column-major, top row first
  localparam bit [8:0] UL = 9'h001, LT = 9'h002, DL = 9'h004;
  localparam bit [8:0] UP = 9'h008, CT = 9'h010, DN = 9'h020;
  localparam bit [8:0] UR = 9'h040, RT = 9'h080, DR = 9'h100;
  localparam bit [8:0] FORK_SHAPES [16] = '{
    LT | UR | DR, UP | DL | DR, UL | DL | RT, UL | UR | DN,
    UL | DN | RT, LT | UP | DR, UP | DL | RT, LT | DN | UR,
    UL | DL | DR, UL | UR | DL, UR | DL | DR, UL | UR | DR,
    LT | RT | DN, LT | RT | UP, UP | DN | LT, UP | DN | RT
  };

  typedef struct packed {
    bit             kind;
    bit [ROW_W-1:0] row;
    bit [COL_W-1:0] column;
    bit [OW-1:0]    orient;
  } minutia_t;

  class minutia_scoreboard;
    bit          older_bits [mwc_pkg::MAX_WIDTH];
    bit          newer_bits [mwc_pkg::MAX_WIDTH];
    bit [OW-1:0] orient_line [mwc_pkg::MAX_WIDTH];
    bit [8:0]    window;
    bit [OW-1:0] orient_prev;
    bit [OW-1:0] orient_prev2;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_reg;
    int unsigned height_reg;
    minutia_t    queued[$];
    int unsigned pixels;
    int unsigned minutiae;
    int unsigned forks;
    int unsigned size_writes;
    int unsigned failures;

    function new();
      width_reg  = 1024;
      height_reg = 1024;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void wrap_pos();
      if (col_pos >= clamp(width_reg, mwc_pkg::MAX_WIDTH)) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= clamp(height_reg, mwc_pkg::HEIGHT_LIMIT)) row_pos = 0;
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void write_reg(logic [mwc_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] v);
      size_writes++;
      if (idx == mwc_pkg::REG_IMAGE_WIDTH) width_reg = v;
      else if (idx == mwc_pkg::REG_IMAGE_HEIGHT) height_reg = v;
    endfunction

    function void note_pixel(bit ridge, bit [OW-1:0] orient);
      int unsigned c;
      int unsigned r;
      bit          hit;
      minutia_t    m;
      wrap_pos();
      c = col_pos % mwc_pkg::MAX_WIDTH;
      r = row_pos;
      window = {ridge, newer_bits[c], older_bits[c], window[8:3]};
      orient_prev2 = orient_prev;
      orient_prev = orient_line[c];
      older_bits[c] = newer_bits[c];
      newer_bits[c] = ridge;
      orient_line[c] = orient;
      pixels++;
      if (r >= 2 && c >= 2 && (window & CT) != 0) begin
        hit = 1'b0;
        foreach (FORK_SHAPES[i])
          if ((window & FORK_SHAPES[i]) == FORK_SHAPES[i]) hit = 1'b1;
        m.kind   = hit;
        m.row    = ROW_W'(r - 1);
        m.column = COL_W'(c - 1);
        m.orient = orient_prev2;
        queued.insert(queued.size(), m);
      end
      col_pos++;
      wrap_pos();
    endfunction

    function void check_minutia(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] column,
                                logic [OW-1:0] orient);
      minutia_t want;
      if (queued.size() == 0) begin
        fail($sformatf("unexpected minutia: type %0d row %0d col %0d orient %h",
                       kind, row, column, orient));
        return;
      end
      want = queued.pop_front();
      minutiae++;
      if (want.kind) forks++;
      if (kind !== want.kind || row !== want.row || column !== want.column ||
          orient !== want.orient)
        fail($sformatf({"minutia mismatch: expected type %0d row %0d col %0d orient %h,",
                        " got type %0d row %0d col %0d orient %h"},
                       want.kind, want.row, want.column, want.orient,
                       kind, row, column, orient));
    endfunction

    function void final_check();
      if (queued.size() != 0) begin
        fail($sformatf("%0d minutiae never arrived", queued.size()));
        failures += queued.size() - 1;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mwc_pixel_if   pix ();
  mwc_minutia_if mnt ();
  mwc_cfg_if     cfg_ch ();

  minutiae_window_classifier u_top (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix),
    .minutia (mnt),
    .cfg     (cfg_ch)
  );

  minutia_scoreboard sb;
  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;
  int hold_left          = 0;
  int cycles             = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      mnt.ready <= 1'b0;
      hold_left--;
    end else begin
      mnt.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && mnt.valid && mnt.ready)
      sb.check_minutia(mnt.minutia_type, mnt.point_row, mnt.point_column,
                       mnt.point_orientation);
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_gap_pct = 46;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_gap_pct = 0;
        receiver_stall_pct = 46;
      end
      default: begin
        sender_gap_pct = 18;
        receiver_stall_pct = 18;
      end
    endcase
  endtask

  function automatic bit [OW-1:0] rand_orient();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return OW'($urandom);
    endcase
  endfunction

  task automatic push_pixel(bit ridge, bit [OW-1:0] orient);
    while ($urandom_range(99) < sender_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.ridge_bit <= ridge;
    pix.orientation_in <= orient;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(ridge, orient);
  endtask

  task automatic push_burst(int n, int density);
    for (int i = 0; i < n; i++) push_pixel($urandom_range(99) < density, rand_orient());
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.queued.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [mwc_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic resize(bit set_w, bit set_h, logic [DW-1:0] w, logic [DW-1:0] h);
    if (set_w) write_reg(mwc_pkg::REG_IMAGE_WIDTH, w);
    if (set_h) write_reg(mwc_pkg::REG_IMAGE_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned random_done;
    int unsigned phase;
    int unsigned n;
    int unsigned density;
    logic [DW-1:0] w;
    logic [DW-1:0] h;
    bit set_w;
    bit set_h;

    sb = new();
    rst <= 1'b1;
    pix.valid <= 1'b0;
    pix.ridge_bit <= 1'b0;
    pix.orientation_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // undersized request saturates to a 3x3 image
    set_idling(0);
    resize(1'b1, 1'b1, 11'd1, 11'd0);
    // all set: border pixels silent, centre is a bifurcation
    for (int i = 0; i < 9; i++) push_pixel(1'b1, (i == 4) ? 16'h7fff : rand_orient());
    // lone centre pixel: ridge ending
    for (int i = 0; i < 9; i++) push_pixel(i == 4, (i == 4) ? 16'h8000 : 16'h0000);
    settle();

    // reach the third row on narrow rows, then widen past the limit for one full row
    set_idling(1);
    resize(1'b1, 1'b1, 11'd3, 11'd2047);
    push_burst(6, 50);
    settle();
    resize(1'b1, 1'b0, 11'd2047, 11'd0);
    push_burst(1024 + 2, 20);
    settle();

    random_done = 0;
    phase = 0;
    while (random_done < RANDOM_PIXELS) begin
      case ($urandom_range(9))
        0: w = DW'($urandom_range(0, 2));
        1: w = DW'($urandom_range(1025, 2047));
        default: w = DW'($urandom_range(3, 12));
      endcase
      case ($urandom_range(9))
        0: h = DW'($urandom_range(0, 2));
        1: h = DW'($urandom_range(1025, 2047));
        default: h = DW'($urandom_range(3, 9));
      endcase
      case ($urandom_range(3))
        0: {set_w, set_h} = 2'b10;
        1: {set_w, set_h} = 2'b01;
        default: {set_w, set_h} = 2'b11;
      endcase
      n = $urandom_range(30, 80);
      density = $urandom_range(30, 85);
      set_idling(phase % 4);
      if (phase == 4) begin
        // long output hold-off while pixels keep coming
        set_idling(0);
        {set_w, set_h} = 2'b11;
        w = 11'd8;
        h = 11'd6;
        n = 200;
        density = 90;
        hold_request = 300;
      end
      resize(set_w, set_h, w, h);
      push_burst(n, density);
      random_done += n;
      phase++;
      settle();
    end

    repeat (6) @(posedge clk);
    sb.final_check();
    $display("covered %0d pixels over %0d size writes, %0d minutiae checked (%0d bifurcations)",
             sb.pixels, sb.size_writes, sb.minutiae, sb.forks);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", sb.failures);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mwc_pkg.sv
rtl/mwc_if.sv
rtl/mwc_raster_pos.sv
rtl/minutiae_window_classifier.sv
rtl/mwc_checker.sv
test/tb_minutiae_window_classifier.sv
